@@ design/mpfl_pkg.sv @@
package mpfl_pkg;

  // Pool geometry
  localparam int SLOT_COUNT = 16;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 3 * ID_W;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Link value that ends a list
  localparam link_t NONE_CODE = LINK_W'(SLOT_COUNT);
  localparam link_t LAST_SLOT = LINK_W'(SLOT_COUNT - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 0,
    OP_FREE   = 1,
    OP_POST   = 2,
    OP_GET    = 3,
    OP_INIT   = 4,
    OP_UNINIT = 5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 0,
    ST_POOL_EMPTY  = 1,
    ST_QUEUE_EMPTY = 2
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOAD,
    S_POST,
    S_DONE
  } state_t;

  // Write request to the link memory
  typedef struct packed {
    logic  we;
    addr_t addr;
    link_t data;
  } link_wr_t;

  // Write request to the message field memory
  typedef struct packed {
    logic              we;
    addr_t             addr;
    logic [DATA_W-1:0] data;
  } data_wr_t;

  // One result transaction
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   sender;
    logic [ID_W-1:0]   receiver;
    logic [ID_W-1:0]   kind;
  } result_t;

  // Any link or head value at or above the slot count means an empty list
  function automatic logic is_slot(link_t v);
    return v < NONE_CODE;
  endfunction

  // Input slot field checked at its own width
  function automatic logic slot_ok(logic [SLOT_W-1:0] s);
    return int'(s) < SLOT_COUNT;
  endfunction

  function automatic addr_t to_addr(link_t v);
    return v[ADDR_W-1:0];
  endfunction

endpackage

@@ design/mpfl_ram.sv @@
module mpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/mpfl_out_reg.sv @@
module mpfl_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  mpfl_pkg::result_t                   result,
  output logic                                out_free,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [mpfl_pkg::STATUS_W-1:0]       status,
  output logic [mpfl_pkg::SLOT_W-1:0]         slot_out,
  output logic [mpfl_pkg::ID_W-1:0]           sender_out,
  output logic [mpfl_pkg::ID_W-1:0]           receiver_out,
  output logic [mpfl_pkg::ID_W-1:0]           kind_out
);

  logic              valid;
  mpfl_pkg::result_t held;

  // Holding register is free when empty or being drained this cycle
  assign out_free = !valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= push || (valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= result;
    end
  end

  assign rsp_valid    = valid;
  assign status       = held.status;
  assign slot_out     = held.slot;
  assign sender_out   = held.sender;
  assign receiver_out = held.receiver;
  assign kind_out     = held.kind;

endmodule

@@ design/mpfl_ctrl.sv @@
module mpfl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  // request side
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [mpfl_pkg::OP_W-1:0]     op,
  input  logic [mpfl_pkg::ID_W-1:0]     sender_id,
  input  logic [mpfl_pkg::ID_W-1:0]     receiver_id,
  input  logic [mpfl_pkg::ID_W-1:0]     kind,
  input  logic [mpfl_pkg::SLOT_W-1:0]   slot,
  // memories
  output mpfl_pkg::link_wr_t            link_wr,
  output mpfl_pkg::data_wr_t            data_wr,
  output mpfl_pkg::addr_t               rd_addr,
  input  mpfl_pkg::link_t               link_rdata,
  input  logic [mpfl_pkg::DATA_W-1:0]   data_rdata,
  // result side
  input  logic                          out_free,
  output logic                          push,
  output mpfl_pkg::result_t             result
);

  mpfl_pkg::state_t  state, state_next;
  mpfl_pkg::link_t   free_head, free_head_next;
  mpfl_pkg::link_t   queue_head, queue_head_next;
  mpfl_pkg::link_t   queue_tail, queue_tail_next;
  mpfl_pkg::link_t   sweep_idx, sweep_idx_next;
  logic              sweep_reply, sweep_reply_next;
  mpfl_pkg::op_t     op_q, op_q_next;
  mpfl_pkg::link_t   slot_q, slot_q_next;
  mpfl_pkg::result_t res, res_next;
  mpfl_pkg::link_t   s_link;

  assign s_link = mpfl_pkg::LINK_W'(slot);
  assign result = res;

  // Next state, list heads and memory requests
  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    sweep_idx_next   = sweep_idx;
    sweep_reply_next = sweep_reply;
    op_q_next        = op_q;
    slot_q_next      = slot_q;
    res_next         = res;
    link_wr          = '0;
    data_wr          = '0;
    rd_addr          = mpfl_pkg::to_addr(queue_head);
    req_ready        = 1'b0;
    push             = 1'b0;

    unique case (state)
      // Rebuild the free list in slot order, one link per cycle
      mpfl_pkg::S_SWEEP: begin
        link_wr.we   = 1'b1;
        link_wr.addr = mpfl_pkg::to_addr(sweep_idx);
        link_wr.data = sweep_idx + 1'b1;
        if (sweep_idx == mpfl_pkg::LAST_SLOT) begin
          free_head_next   = '0;
          queue_head_next  = mpfl_pkg::NONE_CODE;
          queue_tail_next  = mpfl_pkg::NONE_CODE;
          sweep_idx_next   = '0;
          sweep_reply_next = 1'b0;
          state_next       = sweep_reply ? mpfl_pkg::S_DONE : mpfl_pkg::S_IDLE;
        end else begin
          sweep_idx_next = sweep_idx + 1'b1;
        end
      end

      // Accept a transaction and do its first memory access, if it has one
      mpfl_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_q_next  = mpfl_pkg::op_t'(op);
          res_next   = '0;
          state_next = mpfl_pkg::S_DONE;
          unique case (mpfl_pkg::op_t'(op))
            mpfl_pkg::OP_ALLOC: begin
              if (mpfl_pkg::is_slot(free_head)) begin
                rd_addr      = mpfl_pkg::to_addr(free_head);
                data_wr.we   = 1'b1;
                data_wr.addr = mpfl_pkg::to_addr(free_head);
                data_wr.data = {sender_id, receiver_id, kind};
                slot_q_next  = free_head;
                state_next   = mpfl_pkg::S_LOAD;
              end else begin
                res_next.status = mpfl_pkg::ST_POOL_EMPTY;
              end
            end
            mpfl_pkg::OP_FREE: begin
              if (mpfl_pkg::slot_ok(slot)) begin
                link_wr.we     = 1'b1;
                link_wr.addr   = mpfl_pkg::to_addr(s_link);
                link_wr.data   = free_head;
                free_head_next = s_link;
              end
            end
            mpfl_pkg::OP_POST: begin
              if (mpfl_pkg::slot_ok(slot)) begin
                if (!mpfl_pkg::is_slot(queue_head)) begin
                  queue_head_next = s_link;
                end else if (mpfl_pkg::is_slot(queue_tail)) begin
                  link_wr.we   = 1'b1;
                  link_wr.addr = mpfl_pkg::to_addr(queue_tail);
                  link_wr.data = s_link;
                end
                queue_tail_next = s_link;
                slot_q_next     = s_link;
                state_next      = mpfl_pkg::S_POST;
              end
            end
            mpfl_pkg::OP_GET: begin
              if (mpfl_pkg::is_slot(queue_head)) begin
                rd_addr     = mpfl_pkg::to_addr(queue_head);
                slot_q_next = queue_head;
                state_next  = mpfl_pkg::S_LOAD;
              end else begin
                res_next.status = mpfl_pkg::ST_QUEUE_EMPTY;
              end
            end
            mpfl_pkg::OP_INIT: begin
              sweep_reply_next = 1'b1;
              sweep_idx_next   = '0;
              state_next       = mpfl_pkg::S_SWEEP;
            end
            mpfl_pkg::OP_UNINIT: begin
              free_head_next  = mpfl_pkg::NONE_CODE;
              queue_head_next = mpfl_pkg::NONE_CODE;
              queue_tail_next = mpfl_pkg::NONE_CODE;
            end
            default: begin
            end
          endcase
        end
      end

      // Link read data is back: advance the list head
      mpfl_pkg::S_LOAD: begin
        res_next        = '0;
        res_next.status = mpfl_pkg::ST_OK;
        res_next.slot   = mpfl_pkg::SLOT_W'(slot_q);
        if (op_q == mpfl_pkg::OP_GET) begin
          queue_head_next   = link_rdata;
          res_next.sender   = data_rdata[mpfl_pkg::DATA_W-1 -: mpfl_pkg::ID_W];
          res_next.receiver = data_rdata[2*mpfl_pkg::ID_W-1 -: mpfl_pkg::ID_W];
          res_next.kind     = data_rdata[mpfl_pkg::ID_W-1:0];
        end else begin
          free_head_next = link_rdata;
        end
        state_next = mpfl_pkg::S_DONE;
      end

      // Terminate the posted slot
      mpfl_pkg::S_POST: begin
        link_wr.we   = 1'b1;
        link_wr.addr = mpfl_pkg::to_addr(slot_q);
        link_wr.data = mpfl_pkg::NONE_CODE;
        state_next   = mpfl_pkg::S_DONE;
      end

      // Hand the result to the output register
      mpfl_pkg::S_DONE: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = mpfl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mpfl_pkg::S_SWEEP;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mpfl_pkg::S_SWEEP;
      free_head   <= '0;
      queue_head  <= mpfl_pkg::NONE_CODE;
      queue_tail  <= mpfl_pkg::NONE_CODE;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      sweep_idx   <= sweep_idx_next;
      sweep_reply <= sweep_reply_next;
    end
  end

  // Per-transaction payload
  always_ff @(posedge clk) begin
    op_q   <= op_q_next;
    slot_q <= slot_q_next;
    res    <= res_next;
  end

  // A load cycle always follows the accept cycle that issued the read
  a_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == mpfl_pkg::S_LOAD) |-> ($past(state) == mpfl_pkg::S_IDLE))
    else $error("load cycle without a preceding accept");

  // One transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second transaction accepted while busy");

  // Get advances the queue head to the link just read
  a_get_advance: assert property (@(posedge clk) disable iff (rst)
    (state == mpfl_pkg::S_LOAD && op_q == mpfl_pkg::OP_GET)
      |=> (queue_head == $past(link_rdata)))
    else $error("queue head not advanced on get");

  // End of a sweep leaves a full free list and an empty queue
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == mpfl_pkg::S_SWEEP && sweep_idx == mpfl_pkg::LAST_SLOT)
      |=> (free_head == '0 && !mpfl_pkg::is_slot(queue_head)))
    else $error("lists not rebuilt after sweep");

endmodule

@@ design/message_pool_free_list_queue_unit.sv @@
// Flow: an accepted transaction goes straight to done for free, uninitialize, unused codes and
//   empty-list cases, through a load state for allocate and get, a post state for post and a
//   sweep for initialize; done hands the reply to the output register when that is free.
//   Only one transaction is in flight: a new request is taken only after that hand-over.
// Reset: a sweep over every slot rebuilds the free list; req_ready stays low
//   until it finishes. Message field memory is not cleared.
module message_pool_free_list_queue_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [mpfl_pkg::OP_W-1:0]     op,
  input  logic [mpfl_pkg::ID_W-1:0]     sender_id,
  input  logic [mpfl_pkg::ID_W-1:0]     receiver_id,
  input  logic [mpfl_pkg::ID_W-1:0]     kind,
  input  logic [mpfl_pkg::SLOT_W-1:0]   slot,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [mpfl_pkg::STATUS_W-1:0] status,
  output logic [mpfl_pkg::SLOT_W-1:0]   slot_out,
  output logic [mpfl_pkg::ID_W-1:0]     sender_out,
  output logic [mpfl_pkg::ID_W-1:0]     receiver_out,
  output logic [mpfl_pkg::ID_W-1:0]     kind_out
);

  mpfl_pkg::link_wr_t          link_wr;
  mpfl_pkg::data_wr_t          data_wr;
  mpfl_pkg::addr_t             rd_addr;
  mpfl_pkg::link_t             link_rdata;
  logic [mpfl_pkg::DATA_W-1:0] data_rdata;
  logic                        out_free;
  logic                        push;
  mpfl_pkg::result_t           result;

  // Shared link store for the free list and the message queue
  mpfl_ram #(
    .WIDTH (mpfl_pkg::LINK_W),
    .DEPTH (mpfl_pkg::SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // Sender, receiver and kind per slot
  mpfl_ram #(
    .WIDTH (mpfl_pkg::DATA_W),
    .DEPTH (mpfl_pkg::SLOT_COUNT)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_wr.we),
    .waddr (data_wr.addr),
    .wdata (data_wr.data),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  mpfl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .op          (op),
    .sender_id   (sender_id),
    .receiver_id (receiver_id),
    .kind        (kind),
    .slot        (slot),
    .link_wr     (link_wr),
    .data_wr     (data_wr),
    .rd_addr     (rd_addr),
    .link_rdata  (link_rdata),
    .data_rdata  (data_rdata),
    .out_free    (out_free),
    .push        (push),
    .result      (result)
  );

  mpfl_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result       (result),
    .out_free     (out_free),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .slot_out     (slot_out),
    .sender_out   (sender_out),
    .receiver_out (receiver_out),
    .kind_out     (kind_out)
  );

endmodule

@@ bench/mpfl_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the message pool, predicts every reply from its own
// copy of the pool state and compares it with what the block returns.
module mpfl_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  logic [mpfl_pkg::OP_W-1:0]     op,
  input  logic [mpfl_pkg::ID_W-1:0]     sender_id,
  input  logic [mpfl_pkg::ID_W-1:0]     receiver_id,
  input  logic [mpfl_pkg::ID_W-1:0]     kind,
  input  logic [mpfl_pkg::SLOT_W-1:0]   slot,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [mpfl_pkg::STATUS_W-1:0] status,
  input  logic [mpfl_pkg::SLOT_W-1:0]   slot_out,
  input  logic [mpfl_pkg::ID_W-1:0]     sender_out,
  input  logic [mpfl_pkg::ID_W-1:0]     receiver_out,
  input  logic [mpfl_pkg::ID_W-1:0]     kind_out,
  output int                            fail_count,
  output int                            pending_count,
  output logic                          blank_at_queue_head
);
  import mpfl_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the pool
  link_t           next_link    [SLOT_COUNT];
  logic [ID_W-1:0] sender_mem   [SLOT_COUNT];
  logic [ID_W-1:0] receiver_mem [SLOT_COUNT];
  logic [ID_W-1:0] kind_mem     [SLOT_COUNT];
  bit              ever_written [SLOT_COUNT];
  link_t           free_head;
  link_t           queue_head;
  link_t           queue_tail;

  // Replies predicted but not yet returned, oldest first
  result_t awaited_replies[$];

  // A get right now would hand back a slot whose fields were never stored
  assign blank_at_queue_head = (queue_head < NONE_CODE) &&
                               !ever_written[queue_head[ADDR_W-1:0]];

  // Free list in slot order, queue empty
  task automatic rebuild_lists();
    for (int i = 0; i < SLOT_COUNT; i++)
      next_link[i] = link_t'(i + 1);
    free_head  = '0;
    queue_head = NONE_CODE;
    queue_tail = NONE_CODE;
  endtask

  // One pool operation: updates the shadow state and yields the reply
  task automatic apply_pool_op(
    input  logic [OP_W-1:0]   code,
    input  logic [ID_W-1:0]   snd,
    input  logic [ID_W-1:0]   rcv,
    input  logic [ID_W-1:0]   knd,
    input  logic [SLOT_W-1:0] s,
    output result_t           reply
  );
    link_t h;
    reply = '0;
    case (code)
      OP_ALLOC: begin
        h = free_head;
        if (h < NONE_CODE) begin
          free_head                     = next_link[h[ADDR_W-1:0]];
          sender_mem[h[ADDR_W-1:0]]     = snd;
          receiver_mem[h[ADDR_W-1:0]]   = rcv;
          kind_mem[h[ADDR_W-1:0]]       = knd;
          ever_written[h[ADDR_W-1:0]]   = 1'b1;
          reply.slot                    = h[SLOT_W-1:0];
        end else begin
          reply.status = ST_POOL_EMPTY;
        end
      end
      OP_FREE: begin
        if (int'(s) < SLOT_COUNT) begin
          next_link[s] = free_head;
          free_head    = link_t'(s);
        end
      end
      OP_POST: begin
        // emptiness is judged by the head only; tail may be stale after get
        if (int'(s) < SLOT_COUNT) begin
          if (!(queue_head < NONE_CODE))
            queue_head = link_t'(s);
          else if (queue_tail < NONE_CODE)
            next_link[queue_tail[ADDR_W-1:0]] = link_t'(s);
          queue_tail   = link_t'(s);
          next_link[s] = NONE_CODE;
        end
      end
      OP_GET: begin
        h = queue_head;
        if (h < NONE_CODE) begin
          queue_head     = next_link[h[ADDR_W-1:0]];
          reply.slot     = h[SLOT_W-1:0];
          reply.sender   = sender_mem[h[ADDR_W-1:0]];
          reply.receiver = receiver_mem[h[ADDR_W-1:0]];
          reply.kind     = kind_mem[h[ADDR_W-1:0]];
        end else begin
          reply.status = ST_QUEUE_EMPTY;
        end
      end
      OP_INIT: rebuild_lists();
      OP_UNINIT: begin
        free_head  = NONE_CODE;
        queue_head = NONE_CODE;
        queue_tail = NONE_CODE;
      end
      default: ;
    endcase
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      rebuild_lists();
      foreach (ever_written[i]) ever_written[i] = 1'b0;
      awaited_replies.delete();
      fail_count = 0;
    end else begin
      // reply transaction against the oldest prediction
      if (rsp_valid && rsp_ready) begin
        got.status   = status_t'(status);
        got.slot     = slot_out;
        got.sender   = sender_out;
        got.receiver = receiver_out;
        got.kind     = kind_out;
        if (awaited_replies.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: reply with none pending: status=%0d slot=%0d", $realtime,
                     got.status, got.slot);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_LIMIT) begin
              $write("%0t: reply mismatch, expected status=%0d slot=%0d snd=%0h rcv=%0h ",
                     $realtime, want.status, want.slot, want.sender, want.receiver);
              $display("kind=%0h, got status=%0d slot=%0d snd=%0h rcv=%0h kind=%0h",
                       want.kind, got.status, got.slot, got.sender, got.receiver,
                       got.kind);
            end
            fail_count++;
          end
        end
      end
      // request transaction: predict its reply
      if (req_valid && req_ready) begin
        apply_pool_op(op, sender_id, receiver_id, kind, slot, want);
        awaited_replies.push_back(want);
      end
    end
    pending_count = awaited_replies.size();
  end

endmodule

@@ bench/tb_message_pool_free_list_queue_unit.sv @@
`timescale 1ns / 1ps

module tb_message_pool_free_list_queue_unit;
  import mpfl_pkg::*;

  localparam int RANDOM_ITEMS = 1425;
  localparam int WAIT_MAX     = 13;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 500;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = SLOT_COUNT + 8;

  // Op codes outside the defined set
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  logic [OP_W-1:0]     op;
  logic [ID_W-1:0]     sender_id;
  logic [ID_W-1:0]     receiver_id;
  logic [ID_W-1:0]     kind;
  logic [SLOT_W-1:0]   slot;
  logic                rsp_valid;
  logic                rsp_ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [ID_W-1:0]     sender_out;
  logic [ID_W-1:0]     receiver_out;
  logic [ID_W-1:0]     kind_out;

  int   fail_count;
  int   pending_count;
  logic blank_at_queue_head;

  // Ops in flight, and slots handed back by allocate and get, for well-formed sequences
  logic [OP_W-1:0]   sent_ops[$];
  logic [SLOT_W-1:0] held_slots[$];
  logic [SLOT_W-1:0] fetched_slots[$];

  message_pool_free_list_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .op           (op),
    .sender_id    (sender_id),
    .receiver_id  (receiver_id),
    .kind         (kind),
    .slot         (slot),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .slot_out     (slot_out),
    .sender_out   (sender_out),
    .receiver_out (receiver_out),
    .kind_out     (kind_out)
  );

  mpfl_result_checker reply_check (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_valid),
    .req_ready           (req_ready),
    .op                  (op),
    .sender_id           (sender_id),
    .receiver_id         (receiver_id),
    .kind                (kind),
    .slot                (slot),
    .rsp_valid           (rsp_valid),
    .rsp_ready           (rsp_ready),
    .status              (status),
    .slot_out            (slot_out),
    .sender_out          (sender_out),
    .receiver_out        (receiver_out),
    .kind_out            (kind_out),
    .fail_count          (fail_count),
    .pending_count       (pending_count),
    .blank_at_queue_head (blank_at_queue_head)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request transaction after a gap, hold it until accepted
  task automatic offer_item(
    input logic [OP_W-1:0]   code,
    input logic [ID_W-1:0]   snd,
    input logic [ID_W-1:0]   rcv,
    input logic [ID_W-1:0]   knd,
    input logic [SLOT_W-1:0] s,
    input int                gap
  );
    logic [OP_W-1:0] actual;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // never let get reach a slot whose fields were never stored
    actual = code;
    if (code == OP_GET && blank_at_queue_head)
      actual = OP_ALLOC;
    op          <= actual;
    sender_id   <= snd;
    receiver_id <= rcv;
    kind        <= knd;
    slot        <= s;
    req_valid   <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_ops.push_back(actual);
    if (actual == OP_INIT || actual == OP_UNINIT) begin
      held_slots.delete();
      fetched_slots.delete();
    end
  endtask

  // Reply side: random stall per transaction, one long hold to back up the block
  initial begin
    int              stall;
    int              replies;
    logic [OP_W-1:0] origin;
    rsp_ready = 1'b0;
    replies   = 0;
    forever begin
      if (replies == HOLD_AT)
        stall = LONG_HOLD;
      else if ((replies / 128) % 4 == 1)
        stall = 0;
      else
        stall = $urandom_range(0, WAIT_MAX);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      replies++;
      if (sent_ops.size() > 0) begin
        origin = sent_ops.pop_front();
        if (status == ST_OK && origin == OP_ALLOC)
          held_slots.push_back(slot_out);
        else if (status == ST_OK && origin == OP_GET)
          fetched_slots.push_back(slot_out);
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int                n;
    int                pick;
    int                gap;
    logic [OP_W-1:0]   code;
    logic [ID_W-1:0]   snd;
    logic [ID_W-1:0]   rcv;
    logic [ID_W-1:0]   knd;
    logic [SLOT_W-1:0] s;

    rst         = 1'b1;
    req_valid   = 1'b0;
    op          = '0;
    sender_id   = '0;
    receiver_id = '0;
    kind        = '0;
    slot        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lists, field extremes, every op, stale tail, unallocated post
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_ALLOC,  8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_ALLOC,  8'hff, 8'hff, 8'hff, 4'hf,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_POST,   8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_POST,   8'hff, 8'hff, 8'hff, 4'd1,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    // queue drained but tail still points at slot 1
    offer_item(OP_POST,   8'h00, 8'h00, 8'h00, 4'd1,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_FREE,   8'h00, 8'h00, 8'h00, 4'd1,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_FREE,   8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    // unused op codes
    offer_item(OP_SPARE_LO, 8'h5a, 8'ha5, 8'h3c, 4'd7, $urandom_range(0, WAIT_MAX));
    offer_item(OP_SPARE_HI, 8'hff, 8'hff, 8'hff, 4'hf, $urandom_range(0, WAIT_MAX));
    offer_item(OP_UNINIT, 8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_ALLOC,  8'h12, 8'h34, 8'h56, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_FREE,   8'h00, 8'h00, 8'h00, 4'hf,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_ALLOC,  8'ha5, 8'h5a, 8'hc3, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_POST,   8'h00, 8'h00, 8'h00, 4'hf,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_GET,    8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_INIT,   8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_ALLOC,  8'h01, 8'h80, 8'h7f, 4'd0,  $urandom_range(0, WAIT_MAX));
    // post of a slot never allocated, then rebuild
    offer_item(OP_POST,   8'h00, 8'h00, 8'h00, 4'd9,  $urandom_range(0, WAIT_MAX));
    offer_item(OP_INIT,   8'h00, 8'h00, 8'h00, 4'd0,  $urandom_range(0, WAIT_MAX));

    // Random: mostly allocate, post, get, free on slots seen in replies
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      snd  = ID_W'($urandom_range(0, 255));
      rcv  = ID_W'($urandom_range(0, 255));
      knd  = ID_W'($urandom_range(0, 255));
      s    = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      if (pick < 30) begin
        code = OP_ALLOC;
      end else if (pick < 52) begin
        code = OP_POST;
        if (pick < 49 && held_slots.size() > 0) s = held_slots.pop_front();
      end else if (pick < 74) begin
        code = OP_GET;
      end else if (pick < 93) begin
        code = OP_FREE;
        if (pick < 91 && fetched_slots.size() > 0) s = fetched_slots.pop_front();
      end else if (pick < 96) begin
        code = OP_INIT;
      end else if (pick < 98) begin
        code = OP_UNINIT;
      end else begin
        code = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      gap = ((n / 128) % 4 == 3) ? 0 : $urandom_range(0, WAIT_MAX);
      offer_item(code, snd, rcv, knd, s, gap);
      if (code <= OP_UNINIT) n++;
    end

    // Drain and verdict
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mpfl_pkg.sv
design/mpfl_ram.sv
design/mpfl_out_reg.sv
design/mpfl_ctrl.sv
design/message_pool_free_list_queue_unit.sv
bench/mpfl_result_checker.sv
bench/tb_message_pool_free_list_queue_unit.sv
